/* rtl/core/sdt_pkg.sv */
// ----------------------------------------------------------------------------
// sdt_pkg
// Shared types and constants of the sleep deadline table: command and
// result codes, the command word that crosses the front-to-back queue.
// ----------------------------------------------------------------------------
package sdt_pkg;

    // Default configuration
    localparam int TABLE_DEPTH_DEF = 16;
    localparam int ID_WIDTH_DEF    = 8;

    // Fixed field widths of the channels
    localparam int DURATION_W = 32;
    localparam int SLEEPER_W  = 8;
    localparam int KIND_W     = 2;
    localparam int TICK_W     = 64;
    localparam int ID_MAX_W   = 16;

    // Command queue between front and back
    localparam int CMD_Q_DEPTH = 2;
    localparam int CMD_Q_AW    = $clog2(CMD_Q_DEPTH);

    // Input func codes
    localparam logic FUNC_SLEEP = 1'b0;
    localparam logic FUNC_TICK  = 1'b1;

    typedef enum logic {
        OP_SLEEP = 1'b0,
        OP_TICK  = 1'b1
    } t_op;

    typedef enum logic [KIND_W-1:0] {
        KIND_ACCEPT = 2'd0,
        KIND_REJECT = 2'd1,
        KIND_WAKE   = 2'd2
    } t_kind;

    typedef struct packed {
        t_op                   op;
        logic [DURATION_W-1:0] duration;
        logic [SLEEPER_W-1:0]  id;
    } t_cmd;

endpackage

/* rtl/core/sdt_front.sv */
// ----------------------------------------------------------------------------
// sdt_front
// Input side: takes request beats, decodes them into commands and holds
// them in a short queue for the table engine.
// ----------------------------------------------------------------------------
module sdt_front
    import sdt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_func,
    input  logic [DURATION_W-1:0] i_duration,
    input  logic [SLEEPER_W-1:0]  i_sleeper_id,
    output logic                  o_cmd_valid,
    output t_cmd                  o_cmd,
    input  logic                  i_cmd_pop
);

    localparam int CntW = $clog2(CMD_Q_DEPTH + 1);

    t_cmd                r_slot [CMD_Q_DEPTH];
    logic [CMD_Q_AW-1:0] r_wr_ptr;
    logic [CMD_Q_AW-1:0] r_rd_ptr;
    logic [CntW-1:0]     r_fill;
    t_cmd                w_cmd_in;
    logic                w_push;
    logic                w_pop;

    // Decode the beat into a command
    always_comb begin
        w_cmd_in.op       = (i_func == FUNC_TICK) ? OP_TICK : OP_SLEEP;
        w_cmd_in.duration = i_duration;
        w_cmd_in.id       = i_sleeper_id;
    end

    assign o_ready     = (r_fill != CntW'(CMD_Q_DEPTH));
    assign w_push      = i_valid && o_ready;
    assign o_cmd_valid = (r_fill != '0);
    assign w_pop       = i_cmd_pop && o_cmd_valid;
    assign o_cmd       = r_slot[r_rd_ptr];

    // Queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wr_ptr] <= w_cmd_in;
        end
    end

    // Advance pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + CMD_Q_AW'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + CMD_Q_AW'(1);
            end
            if (w_push && !w_pop) begin
                r_fill <= r_fill + CntW'(1);
            end else if (w_pop && !w_push) begin
                r_fill <= r_fill - CntW'(1);
            end
        end
    end

endmodule

/* rtl/core/sdt_back.sv */
// ----------------------------------------------------------------------------
// sdt_back
// Table engine: keeps the tick count and the deadline table, stores sleep
// requests and scans the table on each tick, waking due entries.
// ----------------------------------------------------------------------------
module sdt_back
    import sdt_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int ID_WIDTH    = ID_WIDTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cmd_valid,
    input  t_cmd                                 i_cmd,
    output logic                                 o_cmd_pop,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic [KIND_W-1:0]                    o_kind,
    output logic [SLEEPER_W-1:0]                 o_thread_id,
    output logic                                 o_last,
    output logic [$clog2(TABLE_DEPTH + 1)-1:0]   o_entry_count
);

    localparam int CntW = $clog2(TABLE_DEPTH + 1);
    localparam int IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD,
        ST_CMP,
        ST_MOVE,
        ST_FLUSH
    } t_state;

    // Deadline and owner table
    logic [TICK_W-1:0]   mem_deadline [TABLE_DEPTH];
    logic [ID_WIDTH-1:0] mem_owner    [TABLE_DEPTH];

    t_state              r_state;
    logic [TICK_W-1:0]   r_tick;
    logic [CntW-1:0]     r_count;
    logic [CntW-1:0]     r_idx;
    logic [TICK_W-1:0]   r_rd_deadline;
    logic [ID_WIDTH-1:0] r_rd_owner;
    logic                r_pend_valid;
    logic [ID_WIDTH-1:0] r_pend_owner;
    logic                r_out_valid;
    t_kind               r_out_kind;
    logic [ID_WIDTH-1:0] r_out_id;
    logic                r_out_last;

    logic                w_out_free;
    logic                w_due;
    logic                w_take;
    logic [CntW-1:0]     w_last_idx;
    logic [IdxW-1:0]     w_rd_addr;
    logic                w_wr_en;
    logic [IdxW-1:0]     w_wr_addr;
    logic [TICK_W-1:0]   w_wr_deadline;
    logic [ID_WIDTH-1:0] w_wr_owner;
    logic [ID_MAX_W-1:0] w_id_ext;
    logic [ID_WIDTH-1:0] w_cmd_id;
    logic [ID_MAX_W-1:0] w_out_ext;
    logic                w_full;

    assign w_out_free = !r_out_valid || i_ready;
    assign w_due      = !(r_tick < r_rd_deadline);
    assign w_take     = (r_state == ST_CMP) && w_due && (!r_pend_valid || w_out_free);
    assign w_last_idx = r_count - CntW'(1);
    assign w_full     = (r_count >= CntW'(TABLE_DEPTH));
    assign w_id_ext   = ID_MAX_W'(i_cmd.id);
    assign w_cmd_id   = w_id_ext[ID_WIDTH-1:0];

    // Take a command when idle; a sleep also needs room in the output register
    assign o_cmd_pop = (r_state == ST_IDLE) && i_cmd_valid
                       && ((i_cmd.op == OP_TICK) || w_out_free);

    // Read the last entry once a due entry is taken, else the scan slot
    assign w_rd_addr = w_take ? w_last_idx[IdxW-1:0] : r_idx[IdxW-1:0];

    // Table writes: new sleeper at the end, or last entry into a freed slot
    always_comb begin
        w_wr_en       = 1'b0;
        w_wr_addr     = r_idx[IdxW-1:0];
        w_wr_deadline = r_rd_deadline;
        w_wr_owner    = r_rd_owner;
        if (o_cmd_pop && (i_cmd.op == OP_SLEEP) && !w_full) begin
            w_wr_en       = 1'b1;
            w_wr_addr     = r_count[IdxW-1:0];
            w_wr_deadline = r_tick + TICK_W'(i_cmd.duration);
            w_wr_owner    = w_cmd_id;
        end else if (r_state == ST_MOVE) begin
            w_wr_en = 1'b1;
        end
    end

    // Table memory with registered read
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            mem_deadline[w_wr_addr] <= w_wr_deadline;
            mem_owner[w_wr_addr]    <= w_wr_owner;
        end
        r_rd_deadline <= mem_deadline[w_rd_addr];
        r_rd_owner    <= mem_owner[w_rd_addr];
    end

    // Sequencer, counters and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_tick       <= '0;
            r_count      <= '0;
            r_idx        <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            // Drop a result once its beat is taken
            if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (o_cmd_pop) begin
                        if (i_cmd.op == OP_TICK) begin
                            r_tick  <= r_tick + TICK_W'(1);
                            r_idx   <= '0;
                            r_state <= ST_RD;
                        end else begin
                            r_out_valid <= 1'b1;
                            r_out_id    <= w_cmd_id;
                            r_out_last  <= 1'b1;
                            if (w_full) begin
                                r_out_kind <= KIND_REJECT;
                            end else begin
                                r_out_kind <= KIND_ACCEPT;
                                r_count    <= r_count + CntW'(1);
                            end
                        end
                    end
                end
                ST_RD: begin
                    if (r_idx >= r_count) begin
                        r_state <= ST_FLUSH;
                    end else begin
                        r_state <= ST_CMP;
                    end
                end
                ST_CMP: begin
                    if (!w_due) begin
                        r_idx   <= r_idx + CntW'(1);
                        r_state <= ST_RD;
                    end else if (w_take) begin
                        // Hand the previous wake out; it is not the final one
                        if (r_pend_valid) begin
                            r_out_valid <= 1'b1;
                            r_out_kind  <= KIND_WAKE;
                            r_out_id    <= r_pend_owner;
                            r_out_last  <= 1'b0;
                        end
                        r_pend_valid <= 1'b1;
                        r_pend_owner <= r_rd_owner;
                        r_state      <= ST_MOVE;
                    end
                end
                ST_MOVE: begin
                    // Last entry lands in this slot; check it again
                    r_count <= r_count - CntW'(1);
                    r_state <= ST_RD;
                end
                ST_FLUSH: begin
                    if (!r_pend_valid) begin
                        r_state <= ST_IDLE;
                    end else if (w_out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_kind   <= KIND_WAKE;
                        r_out_id     <= r_pend_owner;
                        r_out_last   <= 1'b1;
                        r_pend_valid <= 1'b0;
                        r_state      <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign w_out_ext     = ID_MAX_W'(r_out_id);
    assign o_valid       = r_out_valid;
    assign o_kind        = r_out_kind;
    assign o_thread_id   = w_out_ext[SLEEPER_W-1:0];
    assign o_last        = r_out_last;
    assign o_entry_count = r_count;

endmodule

/* rtl/core/sleep_deadline_table.sv */
// Sleep result: the input beat is registered in the command queue, then in the result
// register; one sleep per cycle while the result beats are taken and no scan runs.
// Tick: the table engine walks the table one slot at a time, reading and comparing each
// entry and moving the last entry into the slot of each entry woken.
// Up to 2 requests wait in the queue while a scan runs.
// Reset (i_rst_n low, synchronous) clears tick count, entry count and queue;
// the table itself needs no clearing pass.
// ----------------------------------------------------------------------------
// sleep_deadline_table
// Tick counter with an unordered table of sleeper deadlines: stores sleep
// requests and wakes every sleeper whose deadline has been reached on each tick.
// ----------------------------------------------------------------------------
module sleep_deadline_table
    import sdt_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int ID_WIDTH    = ID_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_func,
    input  logic [DURATION_W-1:0] i_duration,
    input  logic [SLEEPER_W-1:0]  i_sleeper_id,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [KIND_W-1:0]     o_kind,
    output logic [SLEEPER_W-1:0]  o_thread_id,
    output logic                  o_last
);

    localparam int CntW = $clog2(TABLE_DEPTH + 1);

    logic            w_cmd_valid;
    t_cmd            w_cmd;
    logic            w_cmd_pop;
    logic [CntW-1:0] w_entry_count;

    sdt_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_func       (i_func),
        .i_duration   (i_duration),
        .i_sleeper_id (i_sleeper_id),
        .o_cmd_valid  (w_cmd_valid),
        .o_cmd        (w_cmd),
        .i_cmd_pop    (w_cmd_pop)
    );

    sdt_back #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .ID_WIDTH    (ID_WIDTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (w_cmd_valid),
        .i_cmd         (w_cmd),
        .o_cmd_pop     (w_cmd_pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_kind        (o_kind),
        .o_thread_id   (o_thread_id),
        .o_last        (o_last),
        .o_entry_count (w_entry_count)
    );

    // Table never holds more entries than it has slots
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_entry_count <= CntW'(TABLE_DEPTH))
        else $error("entry count above table depth");

    // Sleep answers are always the final result of their request
    a_sleep_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_kind != KIND_WAKE)) |-> o_last)
        else $error("sleep answer without last mark");

    // Reset empties the table
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (w_entry_count == '0))
        else $error("table not empty after reset");

    // An accepted sleep grows the table by one
    a_accept_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd_pop && w_cmd_valid && (w_cmd.op == OP_SLEEP)
         && (w_entry_count < CntW'(TABLE_DEPTH)))
        |=> (w_entry_count == $past(w_entry_count) + CntW'(1)))
        else $error("accepted sleep did not add an entry");

endmodule

/* dv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for sleep_deadline_table. Each accepted input beat is
// run through a behavioral copy of the tick counter and deadline table; the
// replies it predicts are queued and compared field by field with every
// output beat. Directed cases come first, then bursts of random traffic with
// random stalls on both sides.
// ----------------------------------------------------------------------------
module testbench;
    import sdt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH       = TABLE_DEPTH_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = 64;
    localparam int MAX_REPORTS = 10;
    localparam logic [SLEEPER_W-1:0] ID_MASK = SLEEPER_W'((1 << ID_WIDTH_DEF) - 1);

    typedef struct packed {
        t_kind                kind;
        logic [SLEEPER_W-1:0] id;
        logic                 last;
    } t_reply;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_ready;
    logic                  i_func;
    logic [DURATION_W-1:0] i_duration;
    logic [SLEEPER_W-1:0]  i_sleeper_id;
    logic                  o_valid;
    logic                  i_ready;
    logic [KIND_W-1:0]     o_kind;
    logic [SLEEPER_W-1:0]  o_thread_id;
    logic                  o_last;

    // Behavioral copy of the block state
    logic [TICK_W-1:0]     now_ticks;
    logic [TICK_W-1:0]     due_at [DEPTH];
    logic [SLEEPER_W-1:0]  sleeper_of [DEPTH];
    logic [4:0]            occupied;

    t_reply expected_replies [$];

    int  error_count;
    int  cycle_count;
    int  accepted_seen;
    int  rejected_seen;
    int  wakes_seen;
    int  ticks_sent;
    bit  tx_idle;
    bit  rx_idle;

    sleep_deadline_table u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_func       (i_func),
        .i_duration   (i_duration),
        .i_sleeper_id (i_sleeper_id),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_kind       (o_kind),
        .o_thread_id  (o_thread_id),
        .o_last       (o_last)
    );

    // Free-running clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Count cycles and stop a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d replies outstanding",
                 cycle_count, expected_replies.size());
        $display("status: fail");
        $finish;
    end

    // Record one failure; print only the first few
    function automatic void log_error(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS) begin
            $display("[%0d] ERROR %s", cycle_count, msg);
        end
    endfunction

    // Append one predicted reply behind the older ones
    function automatic void expect_reply(input t_reply r);
        expected_replies.insert(expected_replies.size(), r);
    endfunction

    // Store a sleeper or refuse it on a full table
    function automatic void apply_sleep(input logic [DURATION_W-1:0] dur,
                                        input logic [SLEEPER_W-1:0] id);
        t_reply r;
        r.id   = id & ID_MASK;
        r.last = 1'b1;
        if (occupied >= DEPTH) begin
            r.kind = KIND_REJECT;
        end else begin
            due_at[occupied]     = now_ticks + TICK_W'(dur);
            sleeper_of[occupied] = id & ID_MASK;
            occupied             = occupied + 1'b1;
            r.kind               = KIND_ACCEPT;
        end
        expect_reply(r);
    endfunction

    // Advance the count, then wake every due sleeper, pulling the tail entry
    // into the freed slot and looking at that slot again
    function automatic void apply_tick();
        logic [SLEEPER_W-1:0] woken [DEPTH];
        int n_woken;
        t_reply r;
        int slot;
        now_ticks = now_ticks + 1'b1;
        n_woken = 0;
        slot = 0;
        while (slot < occupied) begin
            if (now_ticks < due_at[slot]) begin
                slot++;
            end else begin
                woken[n_woken]   = sleeper_of[slot];
                n_woken++;
                occupied         = occupied - 1'b1;
                due_at[slot]     = due_at[occupied];
                sleeper_of[slot] = sleeper_of[occupied];
            end
        end
        for (int k = 0; k < n_woken; k++) begin
            r.kind = KIND_WAKE;
            r.id   = woken[k];
            r.last = (k == n_woken - 1);
            expect_reply(r);
        end
    endfunction

    // Send one input beat, after a random gap when tx_idle is set, then predict its replies
    task automatic send_beat(input t_op op, input logic [DURATION_W-1:0] dur,
                             input logic [SLEEPER_W-1:0] id);
        int gap;
        gap = tx_idle ? $urandom_range(0, 16) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid      <= 1'b1;
        i_func       <= op;
        i_duration   <= dur;
        i_sleeper_id <= id;
        do @(posedge i_clk); while (!o_ready);
        if (op == OP_TICK) begin
            ticks_sent++;
            apply_tick();
        end else begin
            apply_sleep(dur, id);
        end
    endtask

    // Drop valid and hold off until every predicted reply has arrived
    task automatic wait_for_replies();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (expected_replies.size() != 0) @(posedge i_clk);
    endtask

    // Receiver: when rx_idle is set, stall a random number of cycles before each reply beat
    initial begin
        int stall;
        i_ready = 1'b0;
        forever begin
            stall = rx_idle ? $urandom_range(0, 16) : 0;
            if (stall > 0) begin
                @(negedge i_clk);
                i_ready <= 1'b0;
                repeat (stall - 1) @(negedge i_clk);
            end
            @(negedge i_clk);
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_valid && i_ready));
        end
    end

    // Compare each reply beat with the oldest prediction
    always @(posedge i_clk) begin
        t_reply exp_r;
        if (i_rst_n && o_valid && i_ready) begin
            case (o_kind)
                KIND_ACCEPT: accepted_seen++;
                KIND_REJECT: rejected_seen++;
                default:     wakes_seen++;
            endcase
            if (expected_replies.size() == 0) begin
                log_error($sformatf("unexpected reply kind=%0d id=%0d last=%0d",
                                    o_kind, o_thread_id, o_last));
            end else begin
                exp_r = expected_replies.pop_front();
                if (o_kind !== exp_r.kind || o_thread_id !== exp_r.id
                        || o_last !== exp_r.last) begin
                    log_error($sformatf(
                        "reply exp kind=%0d id=%0d last=%0d got kind=%0d id=%0d last=%0d",
                        exp_r.kind, exp_r.id, exp_r.last,
                        o_kind, o_thread_id, o_last));
                end
            end
        end
    end

    // Zero duration wakes at the next tick; an empty table tick says nothing
    task automatic test_short_sleep();
        send_beat(OP_SLEEP, '0, 8'h00);
        send_beat(OP_TICK, '0, 8'h00);
        send_beat(OP_TICK, '1, 8'hFF);
        wait_for_replies();
    endtask

    // Fill the table, refuse one more, then wake all of them on one tick
    task automatic test_full_table();
        for (int k = 0; k < DEPTH; k++) begin
            send_beat(OP_SLEEP, '0, SLEEPER_W'(k * 17));
        end
        send_beat(OP_SLEEP, 32'd5, 8'hA5);
        send_beat(OP_TICK, '0, 8'h5A);
        wait_for_replies();
    endtask

    // The longest sleep stays in the table for the rest of the run
    task automatic test_long_sleep();
        send_beat(OP_SLEEP, '1, 8'hFF);
        send_beat(OP_TICK, '0, 8'h00);
        wait_for_replies();
    endtask

    // Bursts of mixed sleeps and ticks with varying tick density and idling
    task automatic test_random_traffic();
        int tick_pct;
        int pick;
        logic [DURATION_W-1:0] dur;
        t_op op;
        for (int burst = 0; burst < 8; burst++) begin
            case ($urandom_range(0, 2))
                0:       tick_pct = 15;
                1:       tick_pct = 40;
                default: tick_pct = 70;
            endcase
            tx_idle = ($urandom_range(0, 3) != 0);
            rx_idle = ($urandom_range(0, 3) != 0);
            for (int k = 0; k < 20; k++) begin
                if ($urandom_range(0, 99) < tick_pct) begin
                    op = OP_TICK;
                end else begin
                    op = OP_SLEEP;
                end
                pick = $urandom_range(0, 99);
                if (pick < 70) begin
                    dur = $urandom_range(0, 6);
                end else begin
                    dur = $urandom_range(0, 40);
                end
                send_beat(op, dur, SLEEPER_W'($urandom_range(0, 255)));
            end
            if (burst == 3) begin
                wait_for_replies();
            end
        end
        wait_for_replies();
    endtask

    // Main sequence
    initial begin
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_func       = OP_SLEEP;
        i_duration   = '0;
        i_sleeper_id = '0;
        now_ticks    = '0;
        occupied     = '0;
        error_count  = 0;
        cycle_count  = 0;
        tx_idle      = 1'b1;
        rx_idle      = 1'b1;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_short_sleep();
        test_full_table();
        test_long_sleep();
        test_random_traffic();

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (expected_replies.size() != 0) begin
            log_error($sformatf("%0d replies never arrived", expected_replies.size()));
        end

        $display("covered %0d ticks and %0d sleep requests (%0d refused on a full table)",
                 ticks_sent, accepted_seen + rejected_seen, rejected_seen);
        $display("checked %0d wakes, %0d errors", wakes_seen, error_count);
        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
